>>> sv/vchp_pkg.sv
// Package for the video container header parser.
// Record codes, error codes, phase encoding and the parser-to-sequencer event type.
// No dependencies.
package vchp_pkg;

  localparam int unsigned MaxFrames = 1000000;
  localparam int unsigned MaxTracks = 256;
  localparam int unsigned HeaderBytes = 44;

  localparam logic [7:0] MagicB0 = 8'h42;
  localparam logic [7:0] MagicB1 = 8'h49;
  localparam logic [7:0] MagicB2 = 8'h4B;
  localparam logic [7:0] RevB = 8'h62;
  localparam logic [7:0] RevF = 8'h66;
  localparam logic [7:0] RevG = 8'h67;
  localparam logic [7:0] RevH = 8'h68;
  localparam logic [7:0] RevI = 8'h69;
  localparam logic [7:0] RevK = 8'h6B;

  // record kinds
  localparam logic [2:0] KindHdr = 3'd0;
  localparam logic [2:0] KindAud = 3'd1;
  localparam logic [2:0] KindFrm = 3'd2;
  localparam logic [2:0] KindErr = 3'd3;
  localparam logic [2:0] KindEnd = 3'd4;

  // error codes
  localparam logic [3:0] ErrSmall  = 4'd0;
  localparam logic [3:0] ErrMagic  = 4'd1;
  localparam logic [3:0] ErrFrames = 4'd2;
  localparam logic [3:0] ErrDims   = 4'd3;
  localparam logic [3:0] ErrFps    = 4'd4;
  localparam logic [3:0] ErrKtail  = 4'd5;
  localparam logic [3:0] ErrTracks = 4'd6;
  localparam logic [3:0] ErrMaxsz  = 4'd7;
  localparam logic [3:0] ErrAhdr   = 4'd8;
  localparam logic [3:0] ErrTid    = 4'd9;
  localparam logic [3:0] ErrIdx    = 4'd10;
  localparam logic [3:0] ErrOrder  = 4'd11;

  // configuration register indexes
  localparam logic [2:0] CfgAlpha  = 3'd0;
  localparam logic [2:0] CfgGray   = 3'd1;
  localparam logic [2:0] CfgStereo = 3'd2;
  localparam logic [2:0] CfgDct    = 3'd3;
  localparam logic [2:0] CfgWide   = 3'd4;

  typedef enum logic [8:0] {
    PH_HEAD  = 9'b000000001,
    PH_KTAIL = 9'b000000010,
    PH_MAXSZ = 9'b000000100,
    PH_AHDR  = 9'b000001000,
    PH_TID   = 9'b000010000,
    PH_IDX0  = 9'b000100000,
    PH_IDX   = 9'b001000000,
    PH_DONE  = 9'b010000000,
    PH_FAULT = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [2:0]  rec_kind;
    logic [2:0]  field_id;
    logic [19:0] entry_index;
    logic [31:0] value;
    logic [31:0] frame_size;
    logic        keyframe;
    logic [2:0]  decoded_bits;
    logic [3:0]  error_code;
  } rec_t;

  // one accepted byte's worth of results
  typedef struct packed {
    logic             hdr_mode;  // 1: header burst built from the snapshot
    logic [3:0]       cnt;       // number of records, 0 when none
    rec_t             rec0;
    rec_t             rec1;
    logic [7:0]       revision;
    logic [1:0]       hbits;
    logic [6:0][31:0] hw;
  } event_t;

endpackage

>>> sv/vchp_in_if.sv
// Input byte channel interface.
// Depends on nothing.
interface vchp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;
  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface

>>> sv/vchp_out_if.sv
// Result record channel interface.
// Depends on nothing.
interface vchp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  rec_kind;
  logic [2:0]  field_id;
  logic [19:0] entry_index;
  logic [31:0] value;
  logic [31:0] frame_size;
  logic        keyframe;
  logic [2:0]  decoded_bits;
  logic [3:0]  error_code;
  logic        last;
  modport source (output valid, output rec_kind, output field_id, output entry_index,
                  output value, output frame_size, output keyframe, output decoded_bits,
                  output error_code, output last, input ready);
  modport sink (input valid, input rec_kind, input field_id, input entry_index,
                input value, input frame_size, input keyframe, input decoded_bits,
                input error_code, input last, output ready);
endinterface

>>> sv/vchp_cfg_if.sv
// Configuration write channel interface.
// Depends on nothing.
interface vchp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/vchp_parser.sv
// Per-byte parse logic: state registers, mask registers and event generation.
// Depends on vchp_pkg.
module vchp_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  logic [7:0]      data_byte,
  input  logic            end_of_data,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  output vchp_pkg::event_t ev
);
  import vchp_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [5:0]       hbc_r, hbc_nxt;
  logic [1:0]       biw_r, biw_nxt;
  logic [19:0]      item_r, item_nxt;
  logic [31:0]      ws_r, ws_nxt;
  logic             magic_r, magic_nxt;
  logic [7:0]       rev_r, rev_nxt;
  logic [6:0][31:0] hw_r, hw_nxt;
  logic [31:0]      prev_r, prev_nxt;
  logic             fault_r, fault_nxt;

  logic [31:0] alpha_r, gray_r;
  logic [15:0] stereo_r, dct_r, wide_r;

  // mask registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= 32'h0010_0000;
      gray_r   <= 32'h0002_0000;
      stereo_r <= 16'h2000;
      dct_r    <= 16'h1000;
      wide_r   <= 16'h4000;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgAlpha:  alpha_r  <= cfg_data;
        CfgGray:   gray_r   <= cfg_data;
        CfgStereo: stereo_r <= cfg_data[15:0];
        CfgDct:    dct_r    <= cfg_data[15:0];
        CfgWide:   wide_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  function automatic rec_t mk(input logic [2:0] k, input logic [2:0] f,
                              input logic [19:0] i, input logic [31:0] v,
                              input logic [31:0] s, input logic key,
                              input logic [2:0] bt, input logic [3:0] e);
    rec_t r;
    r.rec_kind = k; r.field_id = f; r.entry_index = i; r.value = v;
    r.frame_size = s; r.keyframe = key; r.decoded_bits = bt; r.error_code = e;
    return r;
  endfunction

  logic [6:0]  c1;
  logic [4:0]  wnum;
  logic        full;
  logic [19:0] item_inc;
  logic [31:0] off, fend;
  logic [15:0] afl;
  logic [3:0]  eod_code;

  // next-state and event logic for one byte
  always_comb begin
    phase_nxt = phase_r; hbc_nxt = hbc_r; biw_nxt = biw_r; item_nxt = item_r;
    ws_nxt = ws_r; magic_nxt = magic_r; rev_nxt = rev_r; hw_nxt = hw_r;
    prev_nxt = prev_r; fault_nxt = fault_r;
    ev = '0;
    c1 = 7'({1'b0, hbc_r} + 7'd1);
    wnum = c1[6:2] - 5'd2;
    full = 1'b0;
    item_inc = item_r + 20'd1;
    off = prev_r & ~32'd1;
    afl = 16'(ws_nxt >> 16);
    fend = 32'd0;
    eod_code = ErrIdx;

    if (phase_r != PH_DONE && phase_r != PH_FAULT) begin
      ws_nxt = {data_byte, ws_r[31:8]};
      biw_nxt = biw_r + 2'd1;
      full = (biw_nxt == 2'd0);
      afl = ws_nxt[31:16];
      fend = ws_nxt & ~32'd1;
      if (phase_r == PH_HEAD) begin
        // magic and revision check
        case (hbc_r)
          6'd0: if (data_byte != MagicB0) magic_nxt = 1'b0;
          6'd1: if (data_byte != MagicB1) magic_nxt = 1'b0;
          6'd2: if (data_byte != MagicB2) magic_nxt = 1'b0;
          6'd3: begin
            rev_nxt = data_byte;
            if (!(data_byte == RevB || data_byte == RevF || data_byte == RevG ||
                  data_byte == RevH || data_byte == RevI || data_byte == RevK))
              magic_nxt = 1'b0;
          end
          default: ;
        endcase
        hbc_nxt = c1[5:0];
        if (full && c1 >= 7'd8) begin
          if (wnum == 5'd1) hw_nxt[0] = ws_nxt;
          else if (wnum >= 5'd4 && wnum <= 5'd9) hw_nxt[3'(wnum - 5'd3)] = ws_nxt;
          if (c1 == 7'(HeaderBytes)) begin
            // header checks in precedence order
            ev.revision = rev_nxt;
            ev.hw = hw_nxt;
            ev.hbits = {|(hw_nxt[5] & gray_r), |(hw_nxt[5] & alpha_r)};
            if (!magic_nxt) begin
              ev.cnt = 4'd1; ev.rec0 = mk(KindErr, 3'd0, 20'd0, 32'd0, 32'd0, 1'b0, 3'd0,
                                          ErrMagic);
              phase_nxt = PH_FAULT;
            end else if (hw_nxt[0] == 32'd0 || hw_nxt[0] > 32'(MaxFrames)) begin
              ev.cnt = 4'd1; ev.rec0 = mk(KindErr, 3'd0, 20'd0, 32'd0, 32'd0, 1'b0, 3'd0,
                                          ErrFrames);
              phase_nxt = PH_FAULT;
            end else if (hw_nxt[1] == 32'd0 || hw_nxt[2] == 32'd0) begin
              ev.cnt = 4'd1; ev.rec0 = mk(KindErr, 3'd0, 20'd0, 32'd0, 32'd0, 1'b0, 3'd0,
                                          ErrDims);
              phase_nxt = PH_FAULT;
            end else if (hw_nxt[3] == 32'd0 || hw_nxt[4] == 32'd0) begin
              ev.cnt = 4'd1; ev.rec0 = mk(KindErr, 3'd0, 20'd0, 32'd0, 32'd0, 1'b0, 3'd0,
                                          ErrFps);
              phase_nxt = PH_FAULT;
            end else if (rev_nxt == RevK) begin
              ev.cnt = 4'd8; ev.hdr_mode = 1'b1;
              biw_nxt = 2'd0;
              phase_nxt = PH_KTAIL;
            end else if (hw_nxt[6] > 32'(MaxTracks)) begin
              ev.cnt = 4'd1; ev.rec0 = mk(KindErr, 3'd0, 20'd0, 32'd0, 32'd0, 1'b0, 3'd0,
                                          ErrTracks);
              phase_nxt = PH_FAULT;
            end else begin
              ev.cnt = 4'd8; ev.hdr_mode = 1'b1;
              item_nxt = 20'd0;
              phase_nxt = (hw_nxt[6] != 32'd0) ? PH_MAXSZ : PH_IDX0;
            end
          end
        end
      end else if (full) begin
        // one complete word after the header
        case (phase_r)
          PH_KTAIL: begin
            if (hw_r[6] > 32'(MaxTracks)) begin
              ev.cnt = 4'd1; ev.rec0 = mk(KindErr, 3'd0, 20'd0, 32'd0, 32'd0, 1'b0, 3'd0,
                                          ErrTracks);
              phase_nxt = PH_FAULT;
            end else begin
              item_nxt = 20'd0;
              phase_nxt = (hw_r[6] != 32'd0) ? PH_MAXSZ : PH_IDX0;
            end
          end
          PH_MAXSZ: begin
            ev.cnt = 4'd1;
            ev.rec0 = mk(KindAud, 3'd0, item_r, ws_nxt, 32'd0, 1'b0, 3'd0, ErrSmall);
            item_nxt = item_inc;
            if ({12'd0, item_inc} >= hw_r[6]) begin item_nxt = 20'd0; phase_nxt = PH_AHDR; end
          end
          PH_AHDR: begin
            ev.cnt = 4'd2;
            ev.rec0 = mk(KindAud, 3'd1, item_r, {16'd0, ws_nxt[15:0]}, 32'd0, 1'b0, 3'd0,
                         ErrSmall);
            ev.rec1 = mk(KindAud, 3'd2, item_r, {16'd0, afl}, 32'd0, 1'b0,
                         {|(afl & wide_r), |(afl & dct_r), |(afl & stereo_r)}, ErrSmall);
            item_nxt = item_inc;
            if ({12'd0, item_inc} >= hw_r[6]) begin item_nxt = 20'd0; phase_nxt = PH_TID; end
          end
          PH_TID: begin
            ev.cnt = 4'd1;
            ev.rec0 = mk(KindAud, 3'd3, item_r, ws_nxt, 32'd0, 1'b0, 3'd0, ErrSmall);
            item_nxt = item_inc;
            if ({12'd0, item_inc} >= hw_r[6]) begin item_nxt = 20'd0; phase_nxt = PH_IDX0; end
          end
          PH_IDX0: begin
            prev_nxt = ws_nxt;
            item_nxt = 20'd0;
            phase_nxt = PH_IDX;
          end
          PH_IDX: begin
            if (!fault_r) begin
              if (fend <= off) fault_nxt = 1'b1;
              else begin
                ev.cnt = 4'd1;
                ev.rec0 = mk(KindFrm, 3'd0, item_r, off, fend - off, prev_r[0], 3'd0,
                             ErrSmall);
              end
            end
            prev_nxt = ws_nxt;
            item_nxt = item_inc;
            if ({12'd0, item_inc} >= hw_r[0]) begin
              if (fault_nxt) begin
                ev.cnt = 4'd1;
                ev.rec0 = mk(KindErr, 3'd0, 20'd0, 32'd0, 32'd0, 1'b0, 3'd0, ErrOrder);
                phase_nxt = PH_FAULT;
              end else begin
                if (ev.cnt == 4'd1) begin
                  ev.cnt = 4'd2;
                  ev.rec1 = mk(KindEnd, 3'd0, 20'd0, 32'd0, 32'd0, 1'b0, 3'd0, ErrSmall);
                end else begin
                  ev.cnt = 4'd1;
                  ev.rec0 = mk(KindEnd, 3'd0, 20'd0, 32'd0, 32'd0, 1'b0, 3'd0, ErrSmall);
                end
                phase_nxt = PH_DONE;
              end
            end
          end
          default: ;
        endcase
      end
    end

    // end mark: if unfinished, truncation error replaces records, then rearm
    if (end_of_data) begin
      case (phase_nxt)
        PH_HEAD:  eod_code = ErrSmall;
        PH_KTAIL: eod_code = ErrKtail;
        PH_MAXSZ: eod_code = ErrMaxsz;
        PH_AHDR:  eod_code = ErrAhdr;
        PH_TID:   eod_code = ErrTid;
        default:  eod_code = ErrIdx;
      endcase
      if (phase_nxt != PH_DONE && phase_nxt != PH_FAULT) begin
        ev.cnt = 4'd1; ev.hdr_mode = 1'b0;
        ev.rec0 = mk(KindErr, 3'd0, 20'd0, 32'd0, 32'd0, 1'b0, 3'd0, eod_code);
      end
      phase_nxt = PH_HEAD; hbc_nxt = '0; biw_nxt = '0; item_nxt = '0; ws_nxt = '0;
      magic_nxt = 1'b1; rev_nxt = '0; prev_nxt = '0; fault_nxt = 1'b0; hw_nxt = '0;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD; hbc_r <= '0; biw_r <= '0; item_r <= '0; ws_r <= '0;
      magic_r <= 1'b1; rev_r <= '0; hw_r <= '0; prev_r <= '0; fault_r <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt; hbc_r <= hbc_nxt; biw_r <= biw_nxt; item_r <= item_nxt;
      ws_r <= ws_nxt; magic_r <= magic_nxt; rev_r <= rev_nxt; hw_r <= hw_nxt;
      prev_r <= prev_nxt; fault_r <= fault_nxt;
    end
  end

endmodule

>>> sv/vchp_out_seq.sv
// Result register and record sequencer: one byte's records, one a cycle if ready.
// Depends on vchp_pkg and vchp_out_if.
module vchp_out_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  vchp_pkg::event_t  ev,
  output logic              can_take,
  vchp_out_if.source        out_ch
);
  import vchp_pkg::*;

  logic [3:0]       cnt_r;
  logic [2:0]       pos_r;
  logic             mode_r;
  rec_t             rec0_r, rec1_r;
  logic [7:0]       rev_r;
  logic [1:0]       hbits_r;
  logic [6:0][31:0] hw_r;
  rec_t             cur;
  logic             is_last;
  logic             done;

  assign is_last  = ({1'b0, pos_r} == cnt_r - 4'd1);
  assign done     = out_ch.valid && out_ch.ready && is_last;
  assign can_take = (cnt_r == 4'd0) || done;

  // current record
  always_comb begin
    cur = '0;
    if (mode_r) begin
      cur.rec_kind = KindHdr;
      cur.field_id = pos_r;
      if (pos_r == 3'd0) cur.value = {24'd0, rev_r};
      else cur.value = hw_r[pos_r - 3'd1];
      if (pos_r == 3'd6) cur.decoded_bits = {1'b0, hbits_r};
    end else begin
      cur = (pos_r == 3'd0) ? rec0_r : rec1_r;
    end
  end

  assign out_ch.valid        = (cnt_r != 4'd0);
  assign out_ch.rec_kind     = cur.rec_kind;
  assign out_ch.field_id     = cur.field_id;
  assign out_ch.entry_index  = cur.entry_index;
  assign out_ch.value        = cur.value;
  assign out_ch.frame_size   = cur.frame_size;
  assign out_ch.keyframe     = cur.keyframe;
  assign out_ch.decoded_bits = cur.decoded_bits;
  assign out_ch.error_code   = cur.error_code;
  assign out_ch.last         = is_last;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      pos_r <= '0;
    end else if (load && ev.cnt != 4'd0) begin
      cnt_r <= ev.cnt;
      pos_r <= '0;
    end else if (done) begin
      cnt_r <= '0;
      pos_r <= '0;
    end else if (out_ch.valid && out_ch.ready) begin
      pos_r <= pos_r + 3'd1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load && ev.cnt != 4'd0) begin
      mode_r <= ev.hdr_mode; rec0_r <= ev.rec0; rec1_r <= ev.rec1;
      rev_r <= ev.revision; hbits_r <= ev.hbits; hw_r <= ev.hw;
    end
  end

endmodule

>>> sv/video_container_header_parser_core.sv
// Video container header parser, top level.
// Input channel in_ch: one file byte per word, end_of_data set on the final byte.
// Output channel out_ch: one record per word (header fields, audio track fields,
// frame index entries, errors, completion); last marks the final record of a byte.
// Configuration channel cfg_ch: index 0..4 selects alpha, gray, stereo, dct and
// wide-sample masks; always ready, write only while idle.
// Latency: a byte's first record appears the cycle after the byte is taken.
// Throughput: one byte per cycle while bytes cause at most one record and the
// receiver is ready; records leave one a cycle from the result register, and a
// byte that causes several (header completion gives 8, audio flag words 2)
// holds the input until the same cycle its last pending record is taken.
// Reset: synchronous active-low rst_n clears the parse state and reloads the mask
// defaults; no clearing pass is needed.
// Receiver stall: the current record holds on out_ch and in_ch.ready stays low.
// Depends on vchp_pkg, the three channel interfaces, vchp_parser and vchp_out_seq.
module video_container_header_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  vchp_in_if.sink     in_ch,
  vchp_out_if.source  out_ch,
  vchp_cfg_if.sink    cfg_ch
);
  import vchp_pkg::*;

  event_t ev;
  logic   can_take;
  logic   take;

  assign in_ch.ready  = can_take;
  assign take         = in_ch.valid && can_take;
  assign cfg_ch.ready = 1'b1;

  vchp_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .data_byte   (in_ch.data_byte),
    .end_of_data (in_ch.end_of_data),
    .cfg_we      (cfg_ch.valid),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .ev          (ev)
  );

  vchp_out_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (take),
    .ev       (ev),
    .can_take (can_take),
    .out_ch   (out_ch)
  );

  // new byte is taken only when the pending record is the final one
  a_ready_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.ready && out_ch.valid) |-> out_ch.last)
    else $error("input ready while records still pending");

  // an error record always ends a byte's records and carries a zero value
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.rec_kind == KindErr) |-> (out_ch.last && out_ch.value == 32'd0))
    else $error("error record not final or carries a value");

  // frame sizes are only nonzero on frame entries
  a_size_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.frame_size != 32'd0) |-> (out_ch.rec_kind == KindFrm))
    else $error("frame size on a non-frame record");

endmodule
